// ===== src/ssh_pkg.sv =====
`timescale 1ns / 1ps
package ssh_pkg;

  // Width of the radius register (unsigned fixed point)
  localparam int RADIUS_BITS = 31;

  // Per-transaction decision flags carried down the pipeline
  typedef struct packed {
    logic zero;     // segment has zero length
    logic pneg;     // projection dot product is negative
    logic pzero;    // projection dot product is zero
    logic far_end;  // closest point is the segment end
    logic ovf;      // projection quotient overflows the output range
  } ssh_flags_t;

endpackage

// ===== src/ssh_front.sv =====
`timescale 1ns / 1ps
module ssh_front #(
  parameter int CW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_vld,
  input  logic [9*CW-1:0]         coords,
  output logic                    out_vld,
  output logic [2:0][CW:0]        d,
  output logic [2:0][CW:0]        w,
  output logic [2:0][CW:0]        f,
  output logic [2*CW+1:0]         d2,
  output logic [2*CW+2:0]         p
);
  localparam int DW  = CW + 1;
  localparam int D2W = 2 * DW;
  localparam int PW  = D2W + 1;

  logic [2:0]             vld;
  logic signed [DW-1:0]   d1 [3];
  logic signed [DW-1:0]   w1 [3];
  logic signed [DW-1:0]   f1 [3];
  logic signed [DW-1:0]   d2s [3];
  logic signed [DW-1:0]   w2s [3];
  logic signed [DW-1:0]   f2s [3];
  logic [D2W-1:0]         sq2 [3];
  logic signed [D2W-1:0]  pr2 [3];
  logic [2:0][DW-1:0]     d3;
  logic [2:0][DW-1:0]     w3;
  logic [2:0][DW-1:0]     f3;
  logic [D2W-1:0]         d2_r;
  logic signed [PW-1:0]   p_r;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  // Differences, then products, then sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= DW'(signed'(coords[(3+i)*CW +: CW])) - DW'(signed'(coords[i*CW +: CW]));
        w1[i] <= DW'(signed'(coords[(6+i)*CW +: CW])) - DW'(signed'(coords[i*CW +: CW]));
        f1[i] <= DW'(signed'(coords[(6+i)*CW +: CW])) - DW'(signed'(coords[(3+i)*CW +: CW]));
        d2s[i] <= d1[i];
        w2s[i] <= w1[i];
        f2s[i] <= f1[i];
        sq2[i] <= d1[i] * d1[i];
        pr2[i] <= w1[i] * d1[i];
        d3[i] <= d2s[i];
        w3[i] <= w2s[i];
        f3[i] <= f2s[i];
      end
      d2_r <= sq2[0] + sq2[1] + sq2[2];
      p_r  <= PW'(pr2[0]) + PW'(pr2[1]) + PW'(pr2[2]);
    end
  end

  assign out_vld = vld[2];
  assign d       = d3;
  assign w       = w3;
  assign f       = f3;
  assign d2      = d2_r;
  assign p       = p_r;

endmodule

// ===== src/ssh_isqrt.sv =====
`timescale 1ns / 1ps
module ssh_isqrt #(
  parameter int LW = 33,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [2*LW-1:0] n,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [LW-1:0]   root,
  output logic [SW-1:0]   out_side
);
  localparam int RMW = LW + 3;

  logic            vld_s  [LW+1];
  logic [RMW-1:0]  rem_s  [LW+1];
  logic [LW-1:0]   root_s [LW+1];
  logic [2*LW-1:0] n_s    [LW+1];
  logic [SW-1:0]   side_s [LW+1];

  assign vld_s[0]  = in_vld;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign n_s[0]    = n;
  assign side_s[0] = in_side;

  // One root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < LW; k++) begin : g_step
    logic [RMW-1:0] acc;
    logic [RMW-1:0] trial;
    logic           take;

    always_comb begin
      acc   = {rem_s[k][RMW-3:0], n_s[k][2*LW-1-2*k -: 2]};
      trial = {1'b0, root_s[k], 2'b01};
      take  = (acc >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1]  <= take ? (acc - trial) : acc;
        root_s[k+1] <= {root_s[k][LW-2:0], take};
        n_s[k+1]    <= n_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_vld  = vld_s[LW];
  assign root     = root_s[LW];
  assign out_side = side_s[LW];

endmodule

// ===== src/ssh_udiv.sv =====
`timescale 1ns / 1ps
module ssh_udiv #(
  parameter int DW = 33,
  parameter int QB = 33,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [DW-1:0] rem0,
  input  logic [QB-1:0] lo,
  input  logic [DW-1:0] div,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QB-1:0] quo,
  output logic [SW-1:0] out_side
);
  logic          vld_s  [QB+1];
  logic [DW-1:0] rem_s  [QB+1];
  logic [QB-1:0] lo_s   [QB+1];
  logic [DW-1:0] div_s  [QB+1];
  logic [QB-1:0] q_s    [QB+1];
  logic [SW-1:0] side_s [QB+1];

  assign vld_s[0]  = in_vld;
  assign rem_s[0]  = rem0;
  assign lo_s[0]   = lo;
  assign div_s[0]  = div;
  assign q_s[0]    = '0;
  assign side_s[0] = in_side;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] acc;
    logic [DW:0] diff;
    logic        take;

    always_comb begin
      acc  = {rem_s[k], lo_s[k][QB-1-k]};
      diff = acc - {1'b0, div_s[k]};
      take = (acc >= {1'b0, div_s[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1]  <= take ? diff[DW-1:0] : acc[DW-1:0];
        q_s[k+1]    <= {q_s[k][QB-2:0], take};
        lo_s[k+1]   <= lo_s[k];
        div_s[k+1]  <= div_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_vld  = vld_s[QB];
  assign quo      = q_s[QB];
  assign out_side = side_s[QB];

endmodule

// ===== src/ssh_back.sv =====
`timescale 1ns / 1ps
module ssh_back #(
  parameter int CW = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic [CW:0]                         tq,
  input  ssh_pkg::ssh_flags_t                 flags,
  input  logic [2:0][CW:0]                    qm,
  input  logic [2:0][CW:0]                    w,
  input  logic [2:0][CW:0]                    f,
  input  logic [2:0]                          dneg,
  input  logic [2*ssh_pkg::RADIUS_BITS-1:0]   r_sq,
  output logic                                out_vld,
  output logic                                hit,
  output logic [CW-1:0]                       t
);
  localparam int LW   = CW + 1;
  localparam int RW   = CW + 3;
  localparam int MW   = CW + 2;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int R2W  = 2 * ssh_pkg::RADIUS_BITS;
  localparam int CMPW = (SUMW > R2W) ? SUMW : R2W;

  logic [2:0]           vld;
  logic signed [RW-1:0] qs   [3];
  logic signed [RW-1:0] ri   [3];
  logic [RW-1:0]        rabs [3];
  logic                 sat;
  logic [CW-1:0]        tmag;
  logic [CW-1:0]        tval;
  logic [MW-1:0]        mag_a [3];
  logic [CW-1:0]        t_a;
  logic                 ok_a;
  logic [SQW-1:0]       sq_b [3];
  logic [CW-1:0]        t_b;
  logic                 ok_b;
  logic                 hit_c;
  logic [CW-1:0]        t_c;

  // Residual to the closest point and saturated projection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]   = dneg[i] ? -signed'(RW'(qm[i])) : signed'(RW'(qm[i]));
      ri[i]   = flags.far_end ? RW'(signed'(f[i])) : (RW'(signed'(w[i])) - qs[i]);
      rabs[i] = ri[i][RW-1] ? (~ri[i] + 1'b1) : ri[i];
    end
    sat  = flags.ovf || (tq[LW-1:CW-1] != '0);
    tmag = sat ? (flags.pneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}})
               : tq[CW-1:0];
    tval = flags.zero ? '0 : (flags.pneg ? (~tmag + 1'b1) : tmag);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  // Residual, squares, then sum and compare against radius squared
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag_a[i] <= rabs[i][MW-1:0];
        sq_b[i]  <= mag_a[i] * mag_a[i];
      end
      t_a   <= tval;
      ok_a  <= !flags.zero && !flags.pneg && !flags.pzero;
      t_b   <= t_a;
      ok_b  <= ok_a;
      t_c   <= t_b;
      hit_c <= ok_b && ((CMPW'(sq_b[0]) + CMPW'(sq_b[1]) + CMPW'(sq_b[2])) <= CMPW'(r_sq));
    end
  end

  assign out_vld = vld[2];
  assign hit     = hit_c;
  assign t       = t_c;

endmodule

// ===== src/segment_sphere_hit_test_core.sv =====
`timescale 1ns / 1ps
// Segment against sphere hit test, fully pipelined.
// Input stream (s_tvalid/s_tready/s_tdata) carries one test per transaction:
// start, end and sphere centre as signed fixed point coordinates. Output
// stream (m_tvalid/m_tready/m_tdata) returns one result per test: the hit flag
// and the saturated projection t of the centre onto the segment direction.
// The radius comes from cfg_wr_data, written while cfg_wr_en is high; write
// it only while no transaction is in flight.
// Throughput: one transaction per clock. The pipeline computes differences,
// products and sums, then the square root, then flags and the closest point
// products, then the divisions, and last the distance test.
// Every stage moves on the same advance strobe, open when the output register
// is empty or taken, so a stalled receiver freezes the whole pipeline and
// holds s_tready low; nothing is dropped or repeated.
// Reset clears every valid bit and loads the default radius of 0.2.
// Zero length segments give hit 0 and t 0; a negative projection gives hit 0
// with t carrying the negative value.
module segment_sphere_hit_test_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y, center_z
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]         s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // hit, projection_t
  output logic [((COORD_BITS+1+7)/8)*8-1:0]         m_tdata,
  input  logic                                      cfg_wr_en,
  input  logic [ssh_pkg::RADIUS_BITS-1:0]           cfg_wr_data
);
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int LW  = CW + 1;
  localparam int D2W = 2 * LW;
  localparam int PW  = D2W + 1;
  localparam int NW  = D2W + LW;
  localparam int PC  = (D2W + 2) / 3;
  localparam int OUT_W = ((CW + 1 + 7) / 8) * 8;
  localparam int RB  = ssh_pkg::RADIUS_BITS;
  localparam int FW  = $bits(ssh_pkg::ssh_flags_t);
  localparam int QSW = 1 + 2 * DW;
  localparam int SSW = 9 * DW + PW + D2W;
  localparam logic [RB-1:0] RAD_RST = RB'((64'd1 << FRAC_BITS) / 5);

  logic                adv;
  logic [RB-1:0]       radius;
  logic [2*RB-1:0]     r_sq;

  logic                f_vld;
  logic [2:0][DW-1:0]  f_d;
  logic [2:0][DW-1:0]  f_w;
  logic [2:0][DW-1:0]  f_f;
  logic [D2W-1:0]      f_d2;
  logic [PW-1:0]       f_p;

  logic                r_vld;
  logic [LW-1:0]       r_root;
  logic [SSW-1:0]      r_side;
  logic [2:0][DW-1:0]  q_d;
  logic [2:0][DW-1:0]  q_w;
  logic [2:0][DW-1:0]  q_f;
  logic [PW-1:0]       q_p;
  logic [D2W-1:0]      q_d2;

  logic                pneg_c;
  logic [PW-1:0]       pabs_c;
  logic [2:0][LW-1:0]  dabs_c;

  logic [2:0]               p_vld;
  ssh_pkg::ssh_flags_t      p1_flags;
  ssh_pkg::ssh_flags_t      p2_flags;
  ssh_pkg::ssh_flags_t      p3_flags;
  logic [D2W-1:0]           p1_pmag, p2_pmag, p3_pmag;
  logic [LW-1:0]            p1_root, p2_root, p3_root;
  logic [D2W-1:0]           p1_d2, p2_d2, p3_d2;
  logic [2:0][LW-1:0]       p1_dmag;
  logic [2:0]               p1_dneg, p2_dneg, p3_dneg;
  logic [2:0][DW-1:0]       p1_w, p2_w, p3_w;
  logic [2:0][DW-1:0]       p1_f, p2_f, p3_f;
  logic [3*PC-1:0]          pext;
  logic [2:0][2:0][PC+LW-1:0] p2_pp;
  logic [2:0][NW-1:0]       p3_n;

  logic                td_vld;
  logic [LW-1:0]       td_q;
  logic [FW-1:0]       td_side;
  ssh_pkg::ssh_flags_t td_flags;
  logic [2:0]          qd_vld;
  logic [2:0][LW-1:0]  qd_q;
  logic [2:0][QSW-1:0] qd_side;
  logic [2:0]          qd_dneg;
  logic [2:0][DW-1:0]  qd_w;
  logic [2:0][DW-1:0]  qd_f;

  logic                b_vld;
  logic                b_hit;
  logic [CW-1:0]       b_t;

  // Whole pipeline advances when the output register can move
  assign adv      = !b_vld || m_tready;
  assign s_tready = adv;
  assign m_tvalid = b_vld;
  assign m_tdata  = OUT_W'({b_t, b_hit});

  // Radius register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_RST;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    r_sq <= radius * radius;
  end

  ssh_front #(.CW(CW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (s_tvalid),
    .coords  (s_tdata[9*CW-1:0]),
    .out_vld (f_vld),
    .d       (f_d),
    .w       (f_w),
    .f       (f_f),
    .d2      (f_d2),
    .p       (f_p)
  );

  ssh_isqrt #(.LW(LW), .SW(SSW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (f_vld),
    .n        (f_d2),
    .in_side  ({f_d, f_w, f_f, f_p, f_d2}),
    .out_vld  (r_vld),
    .root     (r_root),
    .out_side (r_side)
  );

  assign {q_d, q_w, q_f, q_p, q_d2} = r_side;

  // Magnitudes and signs after the root
  always_comb begin
    pneg_c = q_p[PW-1];
    pabs_c = pneg_c ? (~q_p + 1'b1) : q_p;
    for (int i = 0; i < 3; i++) begin
      dabs_c[i] = q_d[i][DW-1] ? (~q_d[i] + 1'b1) : q_d[i];
    end
    pext = (3*PC)'(p1_pmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= '0;
    end else if (adv) begin
      p_vld <= {p_vld[1:0], r_vld};
    end
  end

  // Flags, closest point partial products, then their sums
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_flags.zero    <= (q_d2 == '0);
      p1_flags.pneg    <= pneg_c;
      p1_flags.pzero   <= (q_p == '0);
      p1_flags.far_end <= !pneg_c && (q_p[D2W-1:0] >= q_d2);
      p1_flags.ovf     <= 1'b0;
      p1_pmag <= pabs_c[D2W-1:0];
      p1_root <= r_root;
      p1_d2   <= q_d2;
      p1_dmag <= dabs_c;
      for (int i = 0; i < 3; i++) begin
        p1_dneg[i] <= q_d[i][DW-1];
      end
      p1_w <= q_w;
      p1_f <= q_f;

      p2_flags.zero    <= p1_flags.zero;
      p2_flags.pneg    <= p1_flags.pneg;
      p2_flags.pzero   <= p1_flags.pzero;
      p2_flags.far_end <= p1_flags.far_end;
      p2_flags.ovf     <= (p1_pmag[D2W-1:LW] >= p1_root);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_pp[i][j] <= pext[j*PC +: PC] * p1_dmag[i];
        end
      end
      p2_pmag <= p1_pmag;
      p2_root <= p1_root;
      p2_d2   <= p1_d2;
      p2_dneg <= p1_dneg;
      p2_w    <= p1_w;
      p2_f    <= p1_f;

      p3_flags <= p2_flags;
      for (int i = 0; i < 3; i++) begin
        p3_n[i] <= NW'(p2_pp[i][0]) + (NW'(p2_pp[i][1]) << PC)
                 + (NW'(p2_pp[i][2]) << (2*PC));
      end
      p3_pmag <= p2_pmag;
      p3_root <= p2_root;
      p3_d2   <= p2_d2;
      p3_dneg <= p2_dneg;
      p3_w    <= p2_w;
      p3_f    <= p2_f;
    end
  end

  // Projection divider: |P| / L
  ssh_udiv #(.DW(LW), .QB(LW), .SW(FW)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (p_vld[2]),
    .rem0     (p3_pmag[D2W-1:LW]),
    .lo       (p3_pmag[LW-1:0]),
    .div      (p3_root),
    .in_side  (FW'(p3_flags)),
    .out_vld  (td_vld),
    .quo      (td_q),
    .out_side (td_side)
  );

  assign td_flags = ssh_pkg::ssh_flags_t'(td_side);

  // Closest point dividers, one lane per axis: |P| * |d| / D2
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ssh_udiv #(.DW(D2W), .QB(LW), .SW(QSW)) u_qdiv (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (p_vld[2]),
      .rem0     (p3_n[i][NW-1:LW]),
      .lo       (p3_n[i][LW-1:0]),
      .div      (p3_d2),
      .in_side  ({p3_dneg[i], p3_w[i], p3_f[i]}),
      .out_vld  (qd_vld[i]),
      .quo      (qd_q[i]),
      .out_side (qd_side[i])
    );
    assign {qd_dneg[i], qd_w[i], qd_f[i]} = qd_side[i];
  end

  ssh_back #(.CW(CW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (td_vld && (&qd_vld)),
    .tq      (td_q),
    .flags   (td_flags),
    .qm      (qd_q),
    .w       (qd_w),
    .f       (qd_f),
    .dneg    (qd_dneg),
    .r_sq    (r_sq),
    .out_vld (b_vld),
    .hit     (b_hit),
    .t       (b_t)
  );

`ifndef SYNTHESIS
  // A zero length segment always has a zero dot product
  assert property (@(posedge clk) disable iff (rst)
    f_vld && (f_d2 == '0) |-> (f_p == '0))
    else $error("zero length segment with nonzero projection");

  // Square root bounds: root^2 <= D2 < (root+1)^2
  assert property (@(posedge clk) disable iff (rst)
    r_vld |-> (((2*LW+2)'(r_root) * (2*LW+2)'(r_root)) <= (2*LW+2)'(q_d2)) &&
              ((((2*LW+2)'(r_root) + (2*LW+2)'(1)) * ((2*LW+2)'(r_root) + (2*LW+2)'(1)))
                > (2*LW+2)'(q_d2)))
    else $error("square root out of bounds");

  // A hit never reports a negative projection
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[CW])
    else $error("hit with negative projection");
`endif

endmodule

// ===== test/tb_segment_sphere_hit_test_core.sv =====
`timescale 1ns / 1ps
module tb_segment_sphere_hit_test_core;

  localparam int CB = 32;
  localparam int LATENCY = 2 * CB + 11;
  localparam int LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    logic   hit;
    coord_t proj_t;
  } hit_result_t;

  // Predicts hit and projection for each accepted test, checks results in order
  class hit_scoreboard;
    logic [30:0] radius;
    hit_result_t pending[$];
    int errors;

    function new();
      radius = 31'd13107;
      errors = 0;
    endfunction

    static function logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] res;
      logic [63:0] cand;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= n) res = cand;
      end
      return res;
    endfunction

    function void note_test(coord_t s[3], coord_t e[3], coord_t c[3]);
      logic signed [63:0] d[3], w[3], f[3], ri;
      logic signed [127:0] p, q;
      logic [127:0] d2, dist2, r2, pmag, quo, qm;
      logic [63:0] len;
      logic pneg;
      hit_result_t r;
      d2 = 0; p = 0; dist2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 64'(s[i]);
        d[i] = 64'(e[i]) - d[i];
        w[i] = 64'(c[i]) - 64'(s[i]);
        f[i] = 64'(c[i]) - 64'(e[i]);
        d2 += 128'(d[i]) * 128'(d[i]);
        p += 128'(w[i]) * 128'(d[i]);
      end
      r2 = 128'(radius) * 128'(radius);
      if (d2 == 0) begin
        r.hit = 0;
        r.proj_t = 0;
      end else begin
        len = isqrt(d2);
        pneg = p < 0;
        pmag = pneg ? -p : p;
        quo = pmag / 128'(len);
        if (quo > 128'h7fffffff) r.proj_t = pneg ? 32'sh80000000 : 32'sh7fffffff;
        else r.proj_t = pneg ? -coord_t'(quo[31:0]) : coord_t'(quo[31:0]);
        if (pneg || p == 0) r.hit = 0;
        else begin
          if (pmag >= d2) begin
            for (int i = 0; i < 3; i++) dist2 += 128'(f[i]) * 128'(f[i]);
          end else begin
            for (int i = 0; i < 3; i++) begin
              qm = (pmag * 128'(d[i] < 0 ? -d[i] : d[i])) / d2;
              q = d[i] < 0 ? -$signed(qm) : $signed(qm);
              ri = w[i] - 64'(q);
              dist2 += 128'(ri) * 128'(ri);
            end
          end
          r.hit = dist2 <= r2;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic got_hit, coord_t got_t);
      hit_result_t x;
      if (pending.size() == 0) begin
        $error("result with no test outstanding: hit=%0d t=%0d", got_hit, got_t);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got_hit !== x.hit) begin
        $error("hit: expected %0d, actual %0d", x.hit, got_hit);
        errors++;
      end
      if (got_t !== x.proj_t) begin
        $error("projection_t: expected %0d, actual %0d", x.proj_t, got_t);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [9*CB-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [39:0] m_tdata;
  logic cfg_wr_en = 0;
  logic [30:0] cfg_wr_data = '0;

  hit_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;

  segment_sphere_hit_test_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Check each result transaction at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[0], coord_t'(m_tdata[CB:1]));
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls in bursts, none once calm
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      default: return coord_t'($signed($urandom_range(0, 32'h600)) - 32'sh300);
    endcase
  endfunction

  // Send one test and hold it until accepted
  task automatic send_test(coord_t s[3], coord_t e[3], coord_t c[3]);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk);
    end
    s_tdata <= {c[2], c[1], c[0], e[2], e[1], e[0], s[2], s[1], s[0]};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_test(s, e, c);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_radius(logic [30:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.radius = v;
  endtask

  task automatic random_tests(int count);
    coord_t s[3], e[3], c[3];
    int mode;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        s[i] = rand_coord(mode);
        e[i] = ($urandom_range(0, 15) == 0) ? s[i] : rand_coord(mode);
        c[i] = rand_coord(mode);
      end
      // Centre near the segment so hits are common
      if ($urandom_range(0, 1) == 1)
        for (int i = 0; i < 3; i++)
          c[i] = s[i] + ((e[i] - s[i]) >>> $urandom_range(0, 3))
                 + coord_t'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
      send_test(s, e, c);
    end
  endtask

  initial begin
    coord_t s[3], e[3], c[3];
    coord_t mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Zero-length segment
    s = '{32'sh10000, 0, 0}; e = s; c = s;
    send_test(s, e, c);
    // Centre behind the start, and beside the start with zero projection
    s = '{0, 0, 0}; e = '{32'sh10000, 0, 0}; c = '{-32'sh10000, 0, 0};
    send_test(s, e, c);
    c = '{0, 0, 32'sh1000};
    send_test(s, e, c);
    // Centre past the end, close to the segment, off to the side
    c = '{32'sh20000, 0, 0};
    send_test(s, e, c);
    c = '{32'sh8000, 32'sh100, 0};
    send_test(s, e, c);
    c = '{32'sh8000, 32'sh10000, 0};
    send_test(s, e, c);
    // Coordinate extremes, saturating t
    s = '{mn, mn, mn}; e = '{mx, mx, mx}; c = '{mx, mx, mx};
    send_test(s, e, c);
    s = '{mx, mn, 0}; e = '{mn, mx, 0}; c = '{mn, mx, mx};
    send_test(s, e, c);
    s = '{0, 0, 0}; e = '{0, 0, 1}; c = '{0, 0, mx};
    send_test(s, e, c);
    c = '{0, 0, mn};
    send_test(s, e, c);
    s = '{mx, mx, mx}; e = '{mn, mn, mn}; c = '{0, 0, 0};
    send_test(s, e, c);
    drain();

    // Radius settings: zero, maximum, random, then the default again
    write_radius(31'd0);
    random_tests(150);
    drain();
    write_radius(31'h7fffffff);
    random_tests(150);
    // Hold off until every outstanding result is back
    drain();
    write_radius(31'($urandom));
    random_tests(250);
    drain();
    write_radius(31'($urandom_range(1, 32'h40000)));
    random_tests(350);
    drain();
    write_radius(31'd13107);
    random_tests(100);
    calm = 1;
    random_tests(150);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
